// ----- rtl/core/qti_pkg.sv -----
// Package for the quadrilinear table interpolator: function codes, field widths,
// saturation limits and the request/response types of the shared divider and lerp units.
// Used by every module in rtl/core.
package qti_pkg;

	localparam int DEF_MAX_AXIS_POINTS = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int SAT_WIDTH = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam logic signed [31:0] SAT_MAX = 32'((64'sd1 <<< (SAT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [31:0] SAT_MIN = 32'(-(64'sd1 <<< (SAT_WIDTH - 1)));

	localparam int IN_TDATA_W = 176;
	localparam int IN_TUSER_W = 4;
	localparam int OUT_TDATA_W = 32;
	localparam int NUM_CORNERS = 16;
	localparam int NUM_LERPS = 15;
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] W_ONE = 17'h10000;

	typedef enum logic [1:0] {
		FUNC_BP = 2'd0,
		FUNC_TBL = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		AXIS_Z = 2'd0,
		AXIS_C = 2'd1,
		AXIS_ZV = 2'd2,
		AXIS_CV = 2'd3
	} axis_t;

	typedef struct packed {
		logic start;
		logic signed [32:0] num;
		logic signed [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [16:0] w;
	} div_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic [16:0] w;
	} lerp_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] res;
	} lerp_rsp_t;

	function automatic logic signed [31:0] sat_value(logic signed [31:0] x);
		logic signed [31:0] r;
		r = x;
		if (x > SAT_MAX) r = SAT_MAX;
		if (x < SAT_MIN) r = SAT_MIN;
		return r;
	endfunction

endpackage

// ----- rtl/core/quadrilinear_table_interpolator.sv -----
// Top level of the quadrilinear table interpolator: stream ports, configuration registers,
// breakpoint and table memories, and the query sequencer around qti_div and qti_lerp.
// Depends on qti_pkg, qti_div and qti_lerp.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata 176b, s_tuser 4b (write or query)
//  m_*      | out       | m_tvalid/m_tready  | m_tdata 32b interpolated value
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index 2b, cfg_data 5b point count
//
// A query with n points per axis runs, per axis, three breakpoint reads, up to n - 1 search
// steps through the one-port breakpoint memory and a divide, then 5 address steps, 17 table
// reads and 15 lerps before m_tvalid rises.
// s_tready is low while a query runs; the result waits in the output register for m_tready.
// Reset sets every point count to 16; both memories hold nothing until written.
module quadrilinear_table_interpolator #(
	parameter int MAX_AXIS_POINTS = qti_pkg::DEF_MAX_AXIS_POINTS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// address[15:0], data[47:16], q_z[79:48], q_c[111:80], q_zv[143:112], q_cv[175:144]
	input logic [qti_pkg::IN_TDATA_W-1:0] s_tdata,
	// func[1:0], axis_sel[3:2]
	input logic [qti_pkg::IN_TUSER_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// interp_value[31:0]
	output logic [qti_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [4:0] cfg_data
);
	import qti_pkg::*;

	localparam int AW = (MAX_AXIS_POINTS > 1) ? $clog2(MAX_AXIS_POINTS) : 1;
	localparam int CW = $clog2(MAX_AXIS_POINTS + 1);
	localparam int BW = $clog2(4 * MAX_AXIS_POINTS);
	localparam int BP_DEPTH = 4 * MAX_AXIS_POINTS;
	localparam int V_DEPTH = 65536;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_RDLAST = 10'b00_0000_0010,
		S_RDFIRST = 10'b00_0000_0100,
		S_SRCH0 = 10'b00_0000_1000,
		S_SRCH = 10'b00_0001_0000,
		S_DIV = 10'b00_0010_0000,
		S_ADDR = 10'b00_0100_0000,
		S_FETCH = 10'b00_1000_0000,
		S_LERP = 10'b01_0000_0000,
		S_DONE = 10'b10_0000_0000
	} state_t;

	function automatic logic [CW-1:0] pts_clamp(logic [4:0] p);
		logic [CW-1:0] r;
		if (p < 5'd2) r = CW'(2);
		else if (int'(p) > MAX_AXIS_POINTS) r = CW'(MAX_AXIS_POINTS);
		else r = CW'(p);
		return r;
	endfunction

	function automatic logic [BW-1:0] bp_addr(logic [1:0] axis, logic [AW-1:0] idx);
		return BW'(BW'(axis) * BW'(MAX_AXIS_POINTS) + BW'(idx));
	endfunction

	// Input fields.
	logic [1:0] f_func;
	logic [1:0] f_axis;
	logic [15:0] f_address;
	logic signed [31:0] f_data;
	logic signed [31:0] f_q [4];

	assign f_func = s_tuser[1:0];
	assign f_axis = s_tuser[3:2];
	assign f_address = s_tdata[15:0];
	assign f_data = s_tdata[47:16];
	assign f_q[0] = s_tdata[79:48];
	assign f_q[1] = s_tdata[111:80];
	assign f_q[2] = s_tdata[143:112];
	assign f_q[3] = s_tdata[175:144];

	state_t state_q;
	logic [4:0] pts_q [4];
	logic [1:0] axis_q;
	logic [AW-1:0] m_q;
	logic [4:0] j_q;
	logic [3:0] t_q;
	logic [2:0] step_q;
	logic lerp_busy_q;
	logic m_tvalid_q;

	logic signed [31:0] q_q [4];
	logic signed [31:0] q_cur_q;
	logic signed [31:0] prev_q;
	logic [AW-1:0] base_q [4];
	logic [16:0] w_q [4];
	logic [15:0] acc_q;
	logic [15:0] sc_q;
	logic [15:0] sz_q;
	logic signed [31:0] qq_q [NUM_CORNERS];
	logic [31:0] m_tdata_q;

	logic s_acc;
	logic [CW-1:0] n_ax;
	logic [AW-1:0] n_m1;
	logic [CW-1:0] n_c;
	logic [CW-1:0] n_zv;
	logic [CW-1:0] n_cv;

	// Breakpoint memory.
	logic [31:0] bp_mem [BP_DEPTH];
	logic signed [31:0] bp_rd_q;
	logic [BW-1:0] bp_raddr;
	logic bp_we;

	// Table memory.
	logic [31:0] v_mem [V_DEPTH];
	logic signed [31:0] v_rd_q;
	logic [15:0] v_raddr;
	logic v_we;

	logic srch_hit;
	logic signed [32:0] den_raw;
	div_req_t div_req;
	div_rsp_t div_rsp;
	lerp_req_t lerp_req;
	lerp_rsp_t lerp_rsp;
	logic [16:0] w_lerp;
	logic [3:0] wr_slot;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	assign n_ax = pts_clamp(pts_q[axis_q]);
	assign n_m1 = AW'(n_ax - CW'(1));
	assign n_c = pts_clamp(pts_q[AXIS_C]);
	assign n_zv = pts_clamp(pts_q[AXIS_ZV]);
	assign n_cv = pts_clamp(pts_q[AXIS_CV]);

	assign bp_we = s_acc && (f_func == FUNC_BP) && (f_address < 16'(MAX_AXIS_POINTS));
	assign v_we = s_acc && (f_func == FUNC_TBL);

	always_comb begin
		unique case (state_q)
			S_RDLAST: bp_raddr = bp_addr(axis_q, n_m1);
			S_SRCH0: bp_raddr = bp_addr(axis_q, AW'(1));
			S_SRCH: bp_raddr = bp_addr(axis_q, AW'(m_q + AW'(1)));
			default: bp_raddr = bp_addr(axis_q, '0);
		endcase
	end

	always_ff @(posedge clk) begin
		if (bp_we) bp_mem[bp_addr(f_axis, f_address[AW-1:0])] <= f_data;
		bp_rd_q <= bp_mem[bp_raddr];
	end

	// Corner j is fetched in pair order: bit 0 steps zv, bit 1 steps cv, bits 3:2 step z, c.
	assign v_raddr = acc_q + (j_q[3] ? sz_q : 16'd0) + (j_q[2] ? sc_q : 16'd0)
		+ (j_q[0] ? 16'(n_cv) : 16'd0) + 16'(j_q[1]);

	always_ff @(posedge clk) begin
		if (v_we) v_mem[f_address] <= f_data;
		v_rd_q <= v_mem[v_raddr];
	end

	// Search ends at the first breakpoint at or above the clamped query, or at the last.
	assign srch_hit = (state_q == S_SRCH) && ((q_cur_q <= bp_rd_q) || (m_q == n_m1));
	assign den_raw = 33'(bp_rd_q) - 33'(prev_q);
	assign div_req.start = srch_hit;
	assign div_req.num = 33'(q_cur_q) - 33'(prev_q);
	assign div_req.den = (den_raw < 33'sd1) ? 33'sd1 : den_raw;

	qti_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_comb begin
		priority if (t_q < 4'd8) w_lerp = w_q[AXIS_ZV];
		else if (t_q < 4'd12) w_lerp = w_q[AXIS_CV];
		else if (t_q < 4'd14) w_lerp = w_q[AXIS_C];
		else w_lerp = w_q[AXIS_Z];
	end

	assign lerp_req.start = (state_q == S_LERP) && !lerp_busy_q;
	assign lerp_req.a = qq_q[0];
	assign lerp_req.b = qq_q[1];
	assign lerp_req.w = w_lerp;
	assign wr_slot = 4'd14 - t_q;

	qti_lerp u_lerp (
		.clk(clk),
		.arst_n(arst_n),
		.req(lerp_req),
		.rsp(lerp_rsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) pts_q[i] <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				AXIS_Z: pts_q[AXIS_Z] <= cfg_data;
				AXIS_C: pts_q[AXIS_C] <= cfg_data;
				AXIS_ZV: pts_q[AXIS_ZV] <= cfg_data;
				AXIS_CV: pts_q[AXIS_CV] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= '0;
			m_q <= '0;
			j_q <= '0;
			t_q <= '0;
			step_q <= '0;
			lerp_busy_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_acc && f_func == FUNC_QUERY) begin
						axis_q <= '0;
						state_q <= S_RDLAST;
					end
				end
				S_RDLAST: state_q <= S_RDFIRST;
				S_RDFIRST: state_q <= S_SRCH0;
				S_SRCH0: begin
					m_q <= AW'(1);
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (srch_hit) state_q <= S_DIV;
					else m_q <= m_q + AW'(1);
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (axis_q == AXIS_CV) begin
							step_q <= '0;
							state_q <= S_ADDR;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= S_RDLAST;
						end
					end
				end
				S_ADDR: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						j_q <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					j_q <= j_q + 5'd1;
					if (j_q == 5'(NUM_CORNERS)) begin
						t_q <= '0;
						lerp_busy_q <= 1'b0;
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					if (lerp_req.start) lerp_busy_q <= 1'b1;
					if (lerp_rsp.done) begin
						lerp_busy_q <= 1'b0;
						t_q <= t_q + 4'd1;
						if (t_q == 4'(NUM_LERPS - 1)) state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		if (s_acc && f_func == FUNC_QUERY) begin
			for (int i = 0; i < 4; i++) q_q[i] <= f_q[i];
		end
		if (state_q == S_RDLAST) q_cur_q <= q_q[axis_q];
		// Clamp to the last breakpoint first, then to the first one.
		if (state_q == S_RDFIRST && q_cur_q > bp_rd_q) q_cur_q <= bp_rd_q;
		if (state_q == S_SRCH0) begin
			if (q_cur_q < bp_rd_q) q_cur_q <= bp_rd_q;
			prev_q <= bp_rd_q;
		end
		if (state_q == S_SRCH) begin
			if (srch_hit) base_q[axis_q] <= AW'(m_q - AW'(1));
			else prev_q <= bp_rd_q;
		end
		if (state_q == S_DIV && div_rsp.done) w_q[axis_q] <= div_rsp.w;
		if (state_q == S_ADDR) begin
			unique case (step_q)
				3'd0: acc_q <= 16'(16'(base_q[AXIS_Z]) * 16'(n_c)) + 16'(base_q[AXIS_C]);
				3'd1: acc_q <= 16'(acc_q * 16'(n_zv)) + 16'(base_q[AXIS_ZV]);
				3'd2: acc_q <= 16'(acc_q * 16'(n_cv)) + 16'(base_q[AXIS_CV]);
				3'd3: sc_q <= 16'(16'(n_zv) * 16'(n_cv));
				3'd4: sz_q <= 16'(sc_q * 16'(n_c));
				default: ;
			endcase
		end
		if (state_q == S_FETCH && j_q != 5'd0) begin
			for (int i = 0; i < NUM_CORNERS - 1; i++) qq_q[i] <= qq_q[i + 1];
			qq_q[NUM_CORNERS - 1] <= v_rd_q;
		end
		// Each lerp pops the two oldest values and appends its result to the queue.
		if (state_q == S_LERP && lerp_rsp.done) begin
			for (int i = 0; i < NUM_CORNERS; i++) begin
				if (i == int'(wr_slot)) qq_q[i] <= lerp_rsp.res;
				else if (i < NUM_CORNERS - 2) qq_q[i] <= qq_q[i + 2];
			end
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) m_tdata_q <= sat_value(qq_q[0]);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing step");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished while the sequencer was not waiting for it");

	assert property (@(posedge clk) disable iff (!arst_n)
		lerp_rsp.done |-> (state_q == S_LERP && lerp_busy_q))
		else $error("lerp result arrived with no lerp in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> j_q <= 5'(NUM_CORNERS))
		else $error("corner counter ran past the last corner");

endmodule

// ----- rtl/core/qti_div.sv -----
// Radix-2 restoring divider that forms one unsigned Q1.16 interval weight, one quotient bit per cycle.
// Depends on qti_pkg for the request and response types.
module qti_div (
	input logic clk,
	input logic arst_n,
	input qti_pkg::div_req_t req,
	output qti_pkg::div_rsp_t rsp
);
	import qti_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [15:0] quo_q;
	logic [16:0] w_q;
	logic [33:0] r2;
	logic r_ge;
	logic [32:0] rem_next;
	logic [15:0] quo_next;

	assign r2 = {rem_q, 1'b0};
	assign r_ge = (r2 >= {1'b0, den_q});
	assign rem_next = r_ge ? 33'(r2 - {1'b0, den_q}) : r2[32:0];
	assign quo_next = {quo_q[14:0], r_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// A non-positive offset or one that reaches the upper breakpoint
				// finishes at once with a weight of zero or one.
				if (req.num <= 0 || req.num >= req.den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= 5'(FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[32:0];
			den_q <= req.den[32:0];
			quo_q <= '0;
			if (req.num <= 0) w_q <= '0;
			else if (req.num >= req.den) w_q <= W_ONE;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (cnt_q == 5'd1) w_q <= {1'b0, quo_next};
		end
	end

	assign rsp.done = done_q;
	assign rsp.w = w_q;

endmodule

// ----- rtl/core/qti_lerp.sv -----
// Two-stage linear interpolation unit: a + round((b - a) * w / 2^16), halves rounded up.
// Depends on qti_pkg for the request and response types.
module qti_lerp (
	input logic clk,
	input logic arst_n,
	input qti_pkg::lerp_req_t req,
	output qti_pkg::lerp_rsp_t rsp
);
	import qti_pkg::*;

	logic v_s1;
	logic v_s2;
	logic signed [31:0] a_s1;
	logic signed [50:0] prod_s1;
	logic signed [31:0] res_s2;
	logic signed [32:0] diff;
	logic signed [50:0] rnd_sum;
	logic signed [50:0] rnd_q16;

	assign diff = 33'(req.b) - 33'(req.a);
	assign rnd_sum = prod_s1 + 51'sd32768;
	assign rnd_q16 = rnd_sum >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_s1 <= req.a;
			prod_s1 <= 51'(diff * $signed({1'b0, req.w}));
		end
		// With w in 0..1 the sum stays between a and b, so 32 bits hold it.
		if (v_s1) res_s2 <= a_s1 + rnd_q16[31:0];
	end

	assign rsp.done = v_s2;
	assign rsp.res = res_s2;

endmodule
